/* src/rhls_pkg.sv */
// ----------------------------------------------------------------------------
// rhls_pkg
// Shared constants for the RGB to hue/lightness/saturation converter.
// ----------------------------------------------------------------------------
package rhls_pkg;

  // default number of fraction bits on every component
  localparam int unsigned FractionBitsDef = 8;
  // default depth of the queue between front and back (power of two)
  localparam int unsigned QueueDepthDef   = 4;

  // scale points, in whole units before the fraction shift
  localparam int unsigned PctFull   = 100;
  localparam int unsigned DegSector = 60;
  localparam int unsigned DegTurn   = 360;

endpackage

/* src/rhls_front.sv */
// ----------------------------------------------------------------------------
// rhls_front
// Accepts colour words, clamps them, finds the dominant component and works
// out spread, lightness, saturation divisor and the hue numerator offset.
// ----------------------------------------------------------------------------
module rhls_front #(
  parameter  int unsigned FractionBits = rhls_pkg::FractionBitsDef,
  localparam int unsigned CompW        = FractionBits + 7,
  localparam int unsigned OffW         = CompW + 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CompW-1:0] red_i,
  input  logic [CompW-1:0] green_i,
  input  logic [CompW-1:0] blue_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CompW-1:0] del_o,
  output logic [CompW-1:0] den_o,
  output logic [OffW-1:0]  off_o,
  output logic [CompW-1:0] light_o
);
  import rhls_pkg::*;

  typedef enum logic [1:0] {
    SectRed,
    SectGreen,
    SectBlue
  } sector_e;

  localparam int unsigned      SumW    = CompW + 1;
  localparam int unsigned      UW      = CompW + 4;
  localparam logic [CompW-1:0] Full    = CompW'(PctFull << FractionBits);
  localparam logic [SumW-1:0]  TwoFull = SumW'(PctFull << (FractionBits + 1));

  // stage handshake
  logic v1_q, v2_q;
  logic rdy1, rdy2;

  // stage 1 signals
  logic [CompW-1:0] r_c, g_c, b_c;
  logic [CompW-1:0] mx, mn;
  sector_e          sect_d, sect1_q;
  logic [CompW:0]   diff_d, diff1_q;
  logic [CompW-1:0] del_d, del1_q;
  logic [SumW-1:0]  sum_d, sum1_q;

  // stage 2 signals
  logic [SumW-1:0]  sum_p1;
  logic [CompW-1:0] light_d, den_d;
  logic [UW-1:0]    base, diff_ext, u_raw, six_del, u_fix;
  logic [CompW-1:0] del2_q, den2_q, light2_q;
  logic [OffW-1:0]  off2_q;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // clamp, dominant component, spread
  always_comb begin
    r_c = (red_i   > Full) ? Full : red_i;
    g_c = (green_i > Full) ? Full : green_i;
    b_c = (blue_i  > Full) ? Full : blue_i;

    if (r_c >= g_c && r_c >= b_c) begin
      sect_d = SectRed;
      mx     = r_c;
      diff_d = {1'b0, g_c} - {1'b0, b_c};
    end else if (g_c >= b_c) begin
      sect_d = SectGreen;
      mx     = g_c;
      diff_d = {1'b0, b_c} - {1'b0, r_c};
    end else begin
      sect_d = SectBlue;
      mx     = b_c;
      diff_d = {1'b0, r_c} - {1'b0, g_c};
    end

    mn = r_c;
    if (g_c < mn) mn = g_c;
    if (b_c < mn) mn = b_c;

    del_d = mx - mn;
    sum_d = {1'b0, mx} + {1'b0, mn};
  end

  // lightness, divisor, sector offset with wrap into one turn
  always_comb begin
    sum_p1  = sum1_q + SumW'(1);
    light_d = sum_p1[SumW-1:1];
    den_d   = (sum1_q <= {1'b0, Full}) ? sum1_q[CompW-1:0]
                                       : CompW'(TwoFull - sum1_q);

    case (sect1_q)
      SectRed:   base = '0;
      SectGreen: base = UW'({del1_q, 1'b0});
      SectBlue:  base = UW'({del1_q, 2'b00});
      default:   base = '0;
    endcase

    diff_ext = {{3{diff1_q[CompW]}}, diff1_q};
    u_raw    = base + diff_ext;
    six_del  = UW'({del1_q, 2'b00}) + UW'({del1_q, 1'b0});
    u_fix    = u_raw[UW-1] ? (u_raw + six_del) : u_raw;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      sect1_q <= sect_d;
      diff1_q <= diff_d;
      del1_q  <= del_d;
      sum1_q  <= sum_d;
    end
    if (rdy2 && v1_q) begin
      del2_q   <= del1_q;
      den2_q   <= den_d;
      off2_q   <= u_fix[OffW-1:0];
      light2_q <= light_d;
    end
  end

  assign out_valid_o = v2_q;
  assign del_o       = del2_q;
  assign den_o       = den2_q;
  assign off_o       = off2_q;
  assign light_o     = light2_q;

endmodule

/* src/rhls_fifo.sv */
// ----------------------------------------------------------------------------
// rhls_fifo
// Short register queue between front and back; Depth is a power of two.
// ----------------------------------------------------------------------------
module rhls_fifo #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = rhls_pkg::QueueDepthDef,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned CntW  = AddrW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);
  import rhls_pkg::*;

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + AddrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + AddrW'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

endmodule

/* src/rhls_div.sv */
// ----------------------------------------------------------------------------
// rhls_div
// Pipelined restoring divider, one quotient bit per stage. The numerator
// must be below den << QuoW. Advances only when en_i is high.
// ----------------------------------------------------------------------------
module rhls_div #(
  parameter  int unsigned DivW = 15,
  parameter  int unsigned QuoW = 17,
  localparam int unsigned NumW = DivW + QuoW
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);
  import rhls_pkg::*;

  // partial remainder, shifting dividend/quotient word, divisor per stage
  logic [DivW-1:0] rem_q  [QuoW];
  logic [QuoW-1:0] work_q [QuoW];
  logic [DivW-1:0] den_q  [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic [DivW-1:0] rem_in, den_in, rem_nx;
    logic [QuoW-1:0] work_in;
    logic [DivW:0]   part, sub;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = num_i[NumW-1:QuoW];
      assign work_in = num_i[QuoW-1:0];
      assign den_in  = den_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign work_in = work_q[k-1];
      assign den_in  = den_q[k-1];
    end

    // trial subtract of the divisor
    assign part   = {rem_in, work_in[QuoW-1]};
    assign sub    = part - {1'b0, den_in};
    assign ge     = (part >= {1'b0, den_in});
    assign rem_nx = ge ? sub[DivW-1:0] : part[DivW-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_nx;
        work_q[k] <= {work_in[QuoW-2:0], ge};
        den_q[k]  <= den_in;
      end
    end
  end

  assign quo_o = work_q[QuoW-1];

endmodule

/* src/rhls_back.sv */
// ----------------------------------------------------------------------------
// rhls_back
// Forms both dividends, runs the saturation and hue divisions side by side
// and finishes clamp, wrap and grey handling into the output register.
// ----------------------------------------------------------------------------
module rhls_back #(
  parameter  int unsigned FractionBits = rhls_pkg::FractionBitsDef,
  localparam int unsigned CompW        = FractionBits + 7,
  localparam int unsigned OffW         = CompW + 3,
  localparam int unsigned HueW         = FractionBits + 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CompW-1:0] del_i,
  input  logic [CompW-1:0] den_i,
  input  logic [OffW-1:0]  off_i,
  input  logic [CompW-1:0] light_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HueW-1:0]  hue_o,
  output logic [CompW-1:0] light_o,
  output logic [CompW-1:0] sat_o
);
  import rhls_pkg::*;

  localparam int unsigned      QuoW     = HueW;
  localparam int unsigned      NumW     = CompW + QuoW;
  localparam logic [NumW-1:0]  FullN    = NumW'(PctFull << FractionBits);
  localparam logic [NumW-1:0]  SixtyN   = NumW'(DegSector << FractionBits);
  localparam logic [QuoW-1:0]  FullQ    = QuoW'(PctFull << FractionBits);
  localparam logic [HueW-1:0]  FullTurn = HueW'(DegTurn << FractionBits);

  logic en;

  // dividend stage
  logic             v0_q, grey0_q;
  logic [NumW-1:0]  sat_num_q, hue_num_q;
  logic [CompW-1:0] den0_q, del0_q, light0_q;

  // sideband alongside the divider stages
  logic             vld_q   [QuoW];
  logic             grey_q  [QuoW];
  logic [CompW-1:0] light_q [QuoW];

  // quotients and finishing
  logic [QuoW-1:0]  sat_quo, hue_quo;
  logic [QuoW-1:0]  sat_clamp;
  logic [HueW-1:0]  hue_wrap;

  // output register
  logic             out_valid_q;
  logic [HueW-1:0]  hue_q;
  logic [CompW-1:0] lt_q, sat_q;

  // whole pipe freezes while a result waits
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  // rounded dividends: spread*full + den/2 and offset*60deg + spread/2
  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      sat_num_q <= NumW'(del_i) * FullN + NumW'(den_i[CompW-1:1]);
      hue_num_q <= NumW'(off_i) * SixtyN + NumW'(del_i[CompW-1:1]);
      den0_q    <= den_i;
      del0_q    <= del_i;
      light0_q  <= light_i;
      grey0_q   <= (del_i == '0);
    end
  end

  rhls_div #(
    .DivW (CompW),
    .QuoW (QuoW)
  ) u_sat_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sat_num_q),
    .den_i (den0_q),
    .quo_o (sat_quo)
  );

  rhls_div #(
    .DivW (CompW),
    .QuoW (QuoW)
  ) u_hue_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (hue_num_q),
    .den_i (del0_q),
    .quo_o (hue_quo)
  );

  // sideband delay line, matched to divider depth
  for (genvar k = 0; k < QuoW; k++) begin : g_side
    logic             vld_in, grey_in;
    logic [CompW-1:0] light_in;

    if (k == 0) begin : g_first
      assign vld_in   = v0_q;
      assign grey_in  = grey0_q;
      assign light_in = light0_q;
    end else begin : g_next
      assign vld_in   = vld_q[k-1];
      assign grey_in  = grey_q[k-1];
      assign light_in = light_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        grey_q[k]  <= grey_in;
        light_q[k] <= light_in;
      end
    end
  end

  // clamp saturation, wrap a full turn back to zero
  assign sat_clamp = (sat_quo > FullQ) ? FullQ : sat_quo;
  assign hue_wrap  = (hue_quo >= FullTurn) ? (hue_quo - FullTurn) : hue_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[QuoW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[QuoW-1]) begin
      hue_q <= grey_q[QuoW-1] ? '0 : hue_wrap;
      sat_q <= grey_q[QuoW-1] ? '0 : sat_clamp[CompW-1:0];
      lt_q  <= light_q[QuoW-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign hue_o       = hue_q;
  assign light_o     = lt_q;
  assign sat_o       = sat_q;

endmodule

/* src/rgb_to_hls_converter.sv */
// ----------------------------------------------------------------------------
// rgb_to_hls_converter
// Colour space converter: red/green/blue percentages in, hue in degrees and
// lightness/saturation percentages out, all fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   One word in on the s_axis channel carries red, green and blue; one word
//   out on the m_axis channel carries hue, lightness and saturation for it,
//   in the same order. Components above 100 percent are clamped.
//   A word passes two front stages, one queue slot, the dividend stage, the
//   divider and the output register. Throughput is one word per cycle while
//   the output is not held; both divisions are pipelined, one quotient bit
//   per stage over FractionBits + 9 stages. The front end (two stages) feeds
//   a QueueDepth-word queue (four at the default), so words keep coming in
//   while the back end is held. When m_axis_tready is low while a result
//   waits, the back end and its output register freeze; s_axis_tready falls
//   once the queue and front stages are full.
//   Reset clears all valid flags and the queue; the block accepts words as
//   soon as reset is released.
// ----------------------------------------------------------------------------
module rgb_to_hls_converter #(
  parameter  int unsigned FractionBits = rhls_pkg::FractionBitsDef,
  parameter  int unsigned QueueDepth   = rhls_pkg::QueueDepthDef,
  localparam int unsigned CompW        = FractionBits + 7,
  localparam int unsigned HueW         = FractionBits + 9,
  localparam int unsigned InW          = ((3 * CompW + 7) / 8) * 8,
  localparam int unsigned OutW         = ((HueW + 2 * CompW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [InW-1:0]  s_axis_tdata_i,   // red, green, blue
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [OutW-1:0] m_axis_tdata_o    // hue, lightness, saturation
);
  import rhls_pkg::*;

  localparam int unsigned      OffW     = CompW + 3;
  localparam int unsigned      QW       = 3 * CompW + OffW;
  localparam logic [CompW-1:0] Full     = CompW'(PctFull << FractionBits);
  localparam logic [HueW-1:0]  FullTurn = HueW'(DegTurn << FractionBits);

  logic             fr_valid, fr_ready;
  logic [CompW-1:0] fr_del, fr_den, fr_light;
  logic [OffW-1:0]  fr_off;

  logic             q_valid, q_ready;
  logic [QW-1:0]    q_wdata, q_rdata;

  logic [HueW-1:0]  out_hue;
  logic [CompW-1:0] out_light, out_sat;

  rhls_front #(
    .FractionBits (FractionBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .red_i       (s_axis_tdata_i[CompW-1:0]),
    .green_i     (s_axis_tdata_i[2*CompW-1:CompW]),
    .blue_i      (s_axis_tdata_i[3*CompW-1:2*CompW]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .del_o       (fr_del),
    .den_o       (fr_den),
    .off_o       (fr_off),
    .light_o     (fr_light)
  );

  assign q_wdata = {fr_light, fr_off, fr_den, fr_del};

  rhls_fifo #(
    .Width (QW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (q_wdata),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_rdata)
  );

  rhls_back #(
    .FractionBits (FractionBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .del_i       (q_rdata[CompW-1:0]),
    .den_i       (q_rdata[2*CompW-1:CompW]),
    .off_i       (q_rdata[2*CompW+OffW-1:2*CompW]),
    .light_i     (q_rdata[QW-1:2*CompW+OffW]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .hue_o       (out_hue),
    .light_o     (out_light),
    .sat_o       (out_sat)
  );

  assign m_axis_tdata_o = OutW'({out_sat, out_light, out_hue});

`ifndef SYNTHESIS
  // hue always lands inside one turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_hue < FullTurn))
    else $error("hue word at or above a full turn");

  // lightness and saturation never exceed full scale
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_light <= Full) && (out_sat <= Full))
    else $error("percentage word above full scale");

  // any non-zero hue comes from a coloured input, so saturation is non-zero
  a_hue_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_hue != '0)) |-> (out_sat != '0))
    else $error("non-zero hue with zero saturation");

  // input held off only when the queue is full
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> !fr_ready)
    else $error("input stalled with room in the queue");
`endif

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of rgb_to_hls_converter. A directed table covers the
// corners (black, white, primaries, clamping, ties, hue close to a full turn,
// the lightness-above-half branch) and is followed by random pixel words in
// phases with and without idling on either side. Every output word is
// compared with the typed row result or a behavioural model of the conversion.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits = rhls_pkg::FractionBitsDef;
  localparam int unsigned CompW    = FracBits + 7;
  localparam int unsigned HueW     = FracBits + 9;
  localparam int unsigned InW      = ((3 * CompW + 7) / 8) * 8;
  localparam int unsigned OutW     = ((HueW + 2 * CompW + 7) / 8) * 8;

  localparam longint PctFix    = longint'(rhls_pkg::PctFull) << FracBits;
  localparam longint SectorFix = longint'(rhls_pkg::DegSector) << FracBits;
  localparam longint TurnFix   = longint'(rhls_pkg::DegTurn) << FracBits;
  localparam int     CompMax   = (1 << CompW) - 1;

  localparam int RandPerPhase = 160;
  localparam int NumPhases    = 4;
  localparam int HoldCycles   = 300;
  localparam int TailCycles   = 2 * (FracBits + 12);
  localparam int IdleLimit    = 5000;
  localparam int ReportMax    = 10;
  localparam int NumRows      = 18;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [CompW-1:0] light;
    logic [CompW-1:0] sat;
  } hls_t;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
    logic             typed;
    hls_t             known;
  } stim_row_t;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            s_valid      = 1'b0;
  logic [InW-1:0]  s_data       = '0;
  logic            m_ready      = 1'b0;
  logic            s_axis_tready_o;
  logic            m_axis_tvalid_o;
  logic [OutW-1:0] m_axis_tdata_o;

  // typed expectation travelling alongside the word being offered
  logic            stim_typed   = 1'b0;
  hls_t            stim_known   = '0;

  logic            hold_req     = 1'b0;
  logic            hold_done    = 1'b0;
  int              hold_left    = 0;
  int              idle_pct     = 0;
  int              stall_pct    = 0;
  int              n_errors     = 0;
  int              idle_count   = 0;

  hls_t            pending_hls [$];
  stim_row_t       dir_rows [NumRows];

  rgb_to_hls_converter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),          // red, green, blue, zero pad
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)   // hue, lightness, saturation, pad
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // conversion model: clamp, max/min, lightness, saturation, hue sector
  function automatic hls_t hls_of_rgb(logic [CompW-1:0] r_in, logic [CompW-1:0] g_in,
                                      logic [CompW-1:0] b_in);
    longint r, g, b, mx, mn, del, sum, den, u, sat, hue, light;
    hls_t   res;
    r = (longint'(r_in) > PctFix) ? PctFix : longint'(r_in);
    g = (longint'(g_in) > PctFix) ? PctFix : longint'(g_in);
    b = (longint'(b_in) > PctFix) ? PctFix : longint'(b_in);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    del = mx - mn;
    sum = mx + mn;
    sat = 0;
    hue = 0;
    if (del != 0) begin
      den = (sum <= PctFix) ? sum : (2 * PctFix - sum);
      sat = (del * PctFix + den / 2) / den;
      if (sat > PctFix) sat = PctFix;
      // ties resolve to red first, then green
      if (r == mx) u = g - b;
      else if (g == mx) u = 2 * del + b - r;
      else u = 4 * del + r - g;
      if (u < 0) u = u + 6 * del;
      hue = (SectorFix * u + del / 2) / del;
      if (hue >= TurnFix) hue = hue - TurnFix;
    end
    light     = (sum + 1) >> 1;
    res.hue   = hue[HueW-1:0];
    res.light = light[CompW-1:0];
    res.sat   = sat[CompW-1:0];
    return res;
  endfunction

  // one component: mostly in range, some edges, some above full scale
  function automatic logic [CompW-1:0] rand_comp();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CompW'(PctFix);
      2:       return CompW'($urandom_range(CompMax));
      default: return CompW'($urandom_range(int'(PctFix)));
    endcase
  endfunction

  // pixel shapes: greys, ties, near-greys, plain random
  task automatic rand_rgb(output logic [CompW-1:0] r, output logic [CompW-1:0] g,
                          output logic [CompW-1:0] b);
    r = rand_comp();
    g = rand_comp();
    b = rand_comp();
    case ($urandom_range(9))
      0: begin
        g = r;
        b = r;
      end
      1: g = r;
      2: b = g;
      3: b = r;
      4: begin
        g = r ^ CompW'($urandom_range(3));
        b = r ^ CompW'($urandom_range(3));
      end
      default: ;
    endcase
  endtask

  // offer one word; returns at the edge where it is taken
  task automatic offer(input logic [CompW-1:0] r, input logic [CompW-1:0] g,
                       input logic [CompW-1:0] b, input logic typed, input hls_t known);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid    <= 1'b1;
    s_data     <= {{(InW - 3 * CompW){1'b0}}, b, g, r};
    stim_typed <= typed;
    stim_known <= known;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_hls.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_left != 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_ready   <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      m_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // scoreboard: check output words first, then queue the new expectation
  always @(posedge clk_i) begin
    hls_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        got.hue   = m_axis_tdata_o[HueW-1:0];
        got.light = m_axis_tdata_o[HueW+CompW-1:HueW];
        got.sat   = m_axis_tdata_o[HueW+2*CompW-1:HueW+CompW];
        if (pending_hls.size() == 0) begin
          n_errors++;
          if (n_errors <= ReportMax)
            $display("unexpected output word: hue %0d light %0d sat %0d",
                     got.hue, got.light, got.sat);
        end else begin
          want = pending_hls.pop_front();
          if (got != want) begin
            n_errors++;
            if (n_errors <= ReportMax)
              $display("mismatch: hue %0d/%0d light %0d/%0d sat %0d/%0d (exp/got)",
                       want.hue, got.hue, want.light, got.light, want.sat, got.sat);
          end
        end
      end
      if (s_valid && s_axis_tready_o) begin
        if (stim_typed)
          pending_hls.push_back(stim_known);
        else
          pending_hls.push_back(hls_of_rgb(s_data[CompW-1:0], s_data[2*CompW-1:CompW],
                                           s_data[3*CompW-1:2*CompW]));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready))
        idle_count <= 0;
      else
        idle_count <= idle_count + 1;
      if (idle_count >= IdleLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [CompW-1:0] r, g, b;
    int idle_tab [NumPhases];
    int stall_tab [NumPhases];

    idle_tab  = '{0, 62, 0, 20};
    stall_tab = '{0, 0, 62, 20};

    // red, green, blue, typed, {hue, lightness, saturation}
    dir_rows = '{
      '{15'd0,     15'd0,     15'd0,     1'b1, '{17'd0,     15'd0,     15'd0}},
      '{15'd25600, 15'd25600, 15'd25600, 1'b1, '{17'd0,     15'd25600, 15'd0}},
      '{15'd32767, 15'd32767, 15'd32767, 1'b1, '{17'd0,     15'd25600, 15'd0}},
      '{15'd25600, 15'd0,     15'd0,     1'b1, '{17'd0,     15'd12800, 15'd25600}},
      '{15'd0,     15'd25600, 15'd0,     1'b1, '{17'd30720, 15'd12800, 15'd25600}},
      '{15'd0,     15'd0,     15'd25600, 1'b1, '{17'd61440, 15'd12800, 15'd25600}},
      '{15'd32767, 15'd0,     15'd0,     1'b1, '{17'd0,     15'd12800, 15'd25600}},
      '{15'd0,     15'd32767, 15'd32767, 1'b0, '0},
      '{15'd25600, 15'd25600, 15'd0,     1'b0, '0},
      '{15'd0,     15'd25600, 15'd25600, 1'b0, '0},
      '{15'd25600, 15'd0,     15'd25600, 1'b0, '0},
      '{15'd25600, 15'd0,     15'd1,     1'b0, '0},
      '{15'd25600, 15'd25600, 15'd12800, 1'b0, '0},
      '{15'd1,     15'd0,     15'd0,     1'b0, '0},
      '{15'd25600, 15'd25599, 15'd25599, 1'b0, '0},
      '{15'd12800, 15'd12800, 15'd12800, 1'b0, '0},
      '{15'd100,   15'd200,   15'd300,   1'b0, '0},
      '{15'd16384, 15'd32767, 15'd8191,  1'b0, '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners, no idling
    foreach (dir_rows[i])
      offer(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
            dir_rows[i].typed, dir_rows[i].known);

    // random words; sender pauses for a full drain between phases
    for (int phase = 0; phase < NumPhases; phase++) begin
      idle_pct  = idle_tab[phase];
      stall_pct = stall_tab[phase];
      for (int n = 0; n < RandPerPhase; n++) begin
        if (phase == 0 && n == 40) hold_req <= 1'b1;
        rand_rgb(r, g, b);
        offer(r, g, b, 1'b0, '0);
      end
      s_valid <= 1'b0;
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (pending_hls.size() != 0) n_errors++;

    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* files.f */
src/rhls_pkg.sv
src/rhls_front.sv
src/rhls_fifo.sv
src/rhls_div.sv
src/rhls_back.sv
src/rgb_to_hls_converter.sv
tb/testbench.sv
